>>> design/page_latch_table_with_eviction_unit_assert.svh
// Assertion macros used by the page latch table controller.
`ifndef PAGE_LATCH_TABLE_WITH_EVICTION_UNIT_ASSERT_SVH
`define PAGE_LATCH_TABLE_WITH_EVICTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define PLTE_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define PLTE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/plte_pkg.sv
package plte_pkg;

    // Fixed field widths of the request and result
    localparam int PAGE_W   = 32;
    localparam int SLOT_IO_W = 10;
    localparam int STATUS_W = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REUSE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EVICT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;

    // Request types
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef struct packed {
        logic                 req_type;
        logic [PAGE_W-1:0]    page_no;
        logic [SLOT_IO_W-1:0] slot_in;
    } req_t;

    typedef struct packed {
        logic [SLOT_IO_W-1:0] slot_out;
        logic [STATUS_W-1:0]  status;
    } rsp_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_REL,
        OP_HEAD,
        OP_WRD,
        OP_HIT,
        OP_STEP,
        OP_REUSE,
        OP_NEW,
        OP_SRD,
        OP_UNL,
        OP_HEADB,
        OP_LINK1,
        OP_LINK2
    } dp_op_t;

    // Source of the result slot
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_SIN,
        SEL_S,
        SEL_AVAIL,
        SEL_TGT
    } slot_sel_t;

    typedef struct packed {
        dp_op_t               op;
        logic                 emit;
        logic [STATUS_W-1:0]  code;
        slot_sel_t            sel;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_go;
        logic hit;
        logic avail_nz;
        logic room;
        logic sweep_done;
        logic victim_ok;
    } sts_t;

endpackage

>>> design/plte_datapath.sv
module plte_datapath #(
    parameter int ENTRIES     = 1024,
    parameter int BUCKET_BITS = 10,
    parameter int PIN_BITS    = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  plte_pkg::req_t req,
    input  plte_pkg::cmd_t cmd,
    output plte_pkg::sts_t sts,
    output logic           done,
    output plte_pkg::rsp_t rsp
);
    import plte_pkg::*;

    localparam int SLOT_W   = $clog2(ENTRIES);
    localparam int NBUCKETS = 1 << BUCKET_BITS;
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
    localparam logic [PIN_BITS-1:0] PIN_ONE = PIN_BITS'(1);

    // Slot and bucket stores
    logic [PAGE_W-1:0]      slot_page   [ENTRIES];
    logic [BUCKET_BITS-1:0] slot_bucket [ENTRIES];
    logic [SLOT_W-1:0]      slot_prev   [ENTRIES];
    logic [SLOT_W-1:0]      slot_next   [ENTRIES];
    logic [PIN_BITS-1:0]    slot_pins   [ENTRIES];
    logic [SLOT_W-1:0]      bucket_head [NBUCKETS];

    // Working registers
    logic [PAGE_W-1:0]      page_reg;
    logic [SLOT_IO_W-1:0]   sin_reg;
    logic [SLOT_W-1:0]      s_reg, avail_reg, tgt_reg, h_reg;
    logic [SLOT_W:0]        steps_reg, cnt_reg;
    logic [SLOT_W-1:0]      used_reg, sweep_reg;
    logic [BUCKET_BITS-1:0] clr_reg;
    logic                   rd_ok_reg;
    logic [PAGE_W-1:0]      rd_page;
    logic [BUCKET_BITS-1:0] rd_bucket;
    logic [SLOT_W-1:0]      rd_prev, rd_next, head_rd;
    logic [PIN_BITS-1:0]    rd_pins;
    logic                   done_reg;
    rsp_t                   rsp_reg;

    logic [BUCKET_BITS-1:0] b_reg;
    logic [31:0]            sin32;
    logic [31:0]            sinr32;
    logic [PIN_BITS-1:0]    pins_eff;

    assign b_reg    = page_reg[BUCKET_BITS-1:0];
    assign sin32    = 32'(req.slot_in);
    assign sinr32   = 32'(sin_reg);
    assign pins_eff = rd_ok_reg ? rd_pins : '0;

    // Status back to the controller
    always_comb
    begin
        sts.clr_last   = (clr_reg == {BUCKET_BITS{1'b1}});
        sts.walk_go    = (s_reg != '0) && (32'(s_reg) < 32'(ENTRIES))
                         && (32'(steps_reg) < 32'(ENTRIES));
        sts.hit        = (rd_page == page_reg);
        sts.avail_nz   = (avail_reg != '0);
        sts.room       = (32'(used_reg) + 32'd1 < 32'(ENTRIES));
        sts.sweep_done = (32'(cnt_reg) >= 32'(ENTRIES));
        sts.victim_ok  = (tgt_reg != '0) && (pins_eff == '0);
    end

    // Slot read address
    logic              slot_re;
    logic [SLOT_W-1:0] slot_ra;
    logic [31:0]       ra32;
    always_comb
    begin
        slot_re = 1'b0;
        slot_ra = '0;
        ra32    = '0;
        unique case (cmd.op)
            OP_LOAD:
            begin
                slot_re = 1'b1;
                slot_ra = sin32[SLOT_W-1:0];
                ra32    = sin32;
            end
            OP_WRD:
            begin
                slot_re = 1'b1;
                slot_ra = s_reg;
                ra32    = 32'(s_reg);
            end
            OP_SRD:
            begin
                slot_re = 1'b1;
                slot_ra = sweep_reg;
                ra32    = 32'(sweep_reg);
            end
            default: ;
        endcase
    end

    // Head read address
    logic                   head_re;
    logic [BUCKET_BITS-1:0] head_ra;
    always_comb
    begin
        head_re = (cmd.op == OP_LOAD) || (cmd.op == OP_HEADB);
        head_ra = (cmd.op == OP_LOAD) ? req.page_no[BUCKET_BITS-1:0] : b_reg;
    end

    // Write ports, one per store
    logic                   pg_we, bk_we, pv_we, nx_we, pn_we, hd_we;
    logic [SLOT_W-1:0]      pg_wa, bk_wa, pv_wa, nx_wa, pn_wa;
    logic [BUCKET_BITS-1:0] hd_wa;
    logic [SLOT_W-1:0]      pv_wd, nx_wd, hd_wd;
    logic [PIN_BITS-1:0]    pn_wd;
    logic                   p_valid, n_valid, h_valid;

    assign p_valid = (rd_prev != '0) && (32'(rd_prev) < 32'(ENTRIES));
    assign n_valid = (rd_next != '0) && (32'(rd_next) < 32'(ENTRIES));
    assign h_valid = (h_reg != '0) && (32'(h_reg) < 32'(ENTRIES));

    always_comb
    begin
        pg_we = 1'b0; pg_wa = tgt_reg;
        bk_we = 1'b0; bk_wa = tgt_reg;
        pv_we = 1'b0; pv_wa = tgt_reg; pv_wd = '0;
        nx_we = 1'b0; nx_wa = tgt_reg; nx_wd = head_rd;
        pn_we = 1'b0; pn_wa = tgt_reg; pn_wd = PIN_ONE;
        hd_we = 1'b0; hd_wa = b_reg;   hd_wd = tgt_reg;
        unique case (cmd.op)
            OP_CLR:
            begin
                hd_we = 1'b1;
                hd_wa = clr_reg;
                hd_wd = '0;
            end
            OP_REL:
            begin
                pn_we = (pins_eff != '0);
                pn_wa = sinr32[SLOT_W-1:0];
                pn_wd = pins_eff - PIN_ONE;
            end
            OP_HIT:
            begin
                pn_we = 1'b1;
                pn_wa = s_reg;
                pn_wd = (pins_eff == PIN_MAX) ? PIN_MAX : pins_eff + PIN_ONE;
            end
            OP_REUSE:
            begin
                pn_we = 1'b1;
                pn_wa = avail_reg;
                pg_we = 1'b1;
                pg_wa = avail_reg;
            end
            OP_UNL:
            begin
                // drop the victim from its old chain
                if (p_valid)
                begin
                    nx_we = 1'b1;
                    nx_wa = rd_prev;
                    nx_wd = rd_next;
                end
                else
                begin
                    hd_we = 1'b1;
                    hd_wa = rd_bucket;
                    hd_wd = rd_next;
                end
                pv_we = n_valid;
                pv_wa = rd_next;
                pv_wd = rd_prev;
            end
            OP_LINK1:
            begin
                nx_we = 1'b1;
                pg_we = 1'b1;
                bk_we = 1'b1;
                pn_we = 1'b1;
                pv_we = 1'b1;
                hd_we = 1'b1;
            end
            OP_LINK2:
            begin
                pv_we = h_valid;
                pv_wa = h_reg;
                pv_wd = tgt_reg;
            end
            default: ;
        endcase
    end

    // Stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (pg_we) slot_page[pg_wa] <= page_reg;
        if (bk_we) slot_bucket[bk_wa] <= b_reg;
        if (pv_we) slot_prev[pv_wa] <= pv_wd;
        if (nx_we) slot_next[nx_wa] <= nx_wd;
        if (pn_we) slot_pins[pn_wa] <= pn_wd;
        if (hd_we) bucket_head[hd_wa] <= hd_wd;
        if (slot_re)
        begin
            rd_page   <= slot_page[slot_ra];
            rd_bucket <= slot_bucket[slot_ra];
            rd_prev   <= slot_prev[slot_ra];
            rd_next   <= slot_next[slot_ra];
            rd_pins   <= slot_pins[slot_ra];
        end
        if (head_re) head_rd <= bucket_head[head_ra];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            page_reg <= req.page_no;
            sin_reg  <= req.slot_in;
        end
        if (slot_re)
            rd_ok_reg <= (ra32 < 32'(ENTRIES)) && (ra32 != '0)
                         && (ra32 <= 32'(used_reg));
        unique case (cmd.op)
            OP_HEAD:
            begin
                s_reg     <= head_rd;
                steps_reg <= '0;
                avail_reg <= '0;
                cnt_reg   <= '0;
            end
            OP_STEP:
            begin
                if ((pins_eff == '0) && (avail_reg == '0))
                    avail_reg <= s_reg;
                s_reg     <= rd_next;
                steps_reg <= steps_reg + 1'b1;
            end
            OP_NEW:   tgt_reg <= used_reg + 1'b1;
            OP_SRD:
            begin
                tgt_reg <= sweep_reg;
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_LINK1: h_reg <= head_rd;
            default: ;
        endcase
    end

    // Fill count, sweep pointer, clear counter and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            sweep_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLR)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.op == OP_NEW)
                used_reg <= used_reg + 1'b1;
            if (cmd.op == OP_SRD)
                sweep_reg <= (32'(sweep_reg) == 32'(ENTRIES - 1)) ? '0
                             : sweep_reg + 1'b1;
            done_reg <= cmd.emit;
        end
    end

    // Result slot selection
    logic [31:0] slot32;
    always_comb
    begin
        unique case (cmd.sel)
            SEL_SIN:   slot32 = sinr32;
            SEL_S:     slot32 = 32'(s_reg);
            SEL_AVAIL: slot32 = 32'(avail_reg);
            SEL_TGT:   slot32 = 32'(tgt_reg);
            default:   slot32 = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.slot_out <= slot32[SLOT_IO_W-1:0];
            rsp_reg.status   <= cmd.code;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

>>> design/plte_ctrl.sv
module plte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           req_type,
    input  plte_pkg::sts_t sts,
    output plte_pkg::cmd_t cmd,
    output logic           busy
);
    import plte_pkg::*;

    `include "page_latch_table_with_eviction_unit_assert.svh"

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_REL   = 13'b0000000000100,
        S_HEAD  = 13'b0000000001000,
        S_WRD   = 13'b0000000010000,
        S_WCHK  = 13'b0000000100000,
        S_REUSE = 13'b0000001000000,
        S_NEW   = 13'b0000010000000,
        S_SRD   = 13'b0000100000000,
        S_SCHK  = 13'b0001000000000,
        S_HEADB = 13'b0010000000000,
        S_LINK1 = 13'b0100000000000,
        S_LINK2 = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   evict_reg, evict_next;

    // Next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        evict_next = evict_reg;
        cmd.op     = OP_NONE;
        cmd.emit   = 1'b0;
        cmd.code   = ST_HIT;
        cmd.sel    = SEL_ZERO;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = (req_type == REQ_RELEASE) ? S_REL : S_HEAD;
                end
            end
            S_REL:
            begin
                cmd.op     = OP_REL;
                cmd.emit   = 1'b1;
                cmd.code   = ST_RELEASED;
                cmd.sel    = SEL_SIN;
                state_next = S_IDLE;
            end
            S_HEAD:
            begin
                cmd.op     = OP_HEAD;
                state_next = S_WRD;
            end
            S_WRD:
            begin
                priority if (sts.walk_go)
                begin
                    cmd.op     = OP_WRD;
                    state_next = S_WCHK;
                end
                else if (sts.avail_nz)
                    state_next = S_REUSE;
                else if (sts.room)
                    state_next = S_NEW;
                else
                    state_next = S_SRD;
            end
            S_WCHK:
            begin
                if (sts.hit)
                begin
                    cmd.op     = OP_HIT;
                    cmd.emit   = 1'b1;
                    cmd.code   = ST_HIT;
                    cmd.sel    = SEL_S;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_STEP;
                    state_next = S_WRD;
                end
            end
            S_REUSE:
            begin
                cmd.op     = OP_REUSE;
                cmd.emit   = 1'b1;
                cmd.code   = ST_REUSE;
                cmd.sel    = SEL_AVAIL;
                state_next = S_IDLE;
            end
            S_NEW:
            begin
                cmd.op     = OP_NEW;
                evict_next = 1'b0;
                state_next = S_HEADB;
            end
            S_SRD:
            begin
                if (sts.sweep_done)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = ST_NONE;
                    cmd.sel    = SEL_ZERO;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_SRD;
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (sts.victim_ok)
                begin
                    cmd.op     = OP_UNL;
                    evict_next = 1'b1;
                    state_next = S_HEADB;
                end
                else
                    state_next = S_SRD;
            end
            S_HEADB:
            begin
                cmd.op     = OP_HEADB;
                state_next = S_LINK1;
            end
            S_LINK1:
            begin
                cmd.op     = OP_LINK1;
                state_next = S_LINK2;
            end
            S_LINK2:
            begin
                cmd.op     = OP_LINK2;
                cmd.emit   = 1'b1;
                cmd.code   = evict_reg ? ST_EVICT : ST_NEW;
                cmd.sel    = SEL_TGT;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            evict_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            evict_reg <= evict_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Checks
    `PLTE_ASSERT_NEXT(a_emit_ends, cmd.emit, state_reg == S_IDLE,
        "result issued but request not finished")
    `PLTE_ASSERT_NEXT(a_accept_leaves_idle, start && !busy,
        state_reg == S_REL || state_reg == S_HEAD, "accepted request not started")
    `PLTE_ASSERT_NOW(a_link_order, state_reg == S_LINK2, $past(state_reg) == S_LINK1,
        "link second half without first half")

endmodule

>>> design/page_latch_table_with_eviction_unit.sv
// Channel   Handshake            Payload
// request   start / busy         req (req_type, page_no, slot_in)
// result    done, one cycle      rsp (slot_out, status)
//
// Release: load, then release. Acquire: load, read the bucket head, then read
// and check each chain slot walked. A miss reuses an unpinned slot met on the
// walk, else links in a new slot, else sweeps for an unpinned victim to evict
// and relink (result none when none is free); the slot stores set the pace.
// After reset the 2^BUCKET_BITS bucket heads are cleared, one per cycle, with
// busy high. The result cannot be stalled.
module page_latch_table_with_eviction_unit #(
    parameter int ENTRIES     = 1024,
    parameter int BUCKET_BITS = 10,
    parameter int PIN_BITS    = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  plte_pkg::req_t req,
    output logic           done,
    output plte_pkg::rsp_t rsp
);
    import plte_pkg::*;

    cmd_t cmd;
    sts_t sts;

    plte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req.req_type),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    plte_datapath #(
        .ENTRIES     (ENTRIES),
        .BUCKET_BITS (BUCKET_BITS),
        .PIN_BITS    (PIN_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

endmodule
